// ===== src/pcc_pkg.sv =====
// pcc_pkg: shared types and constants of the polygon concavity check unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pcc_pkg;

    // default coordinate width, signed Q8.8
    localparam int COORD_BITS_DEF = 16;
    // width of the turn threshold register
    localparam int EPS_BITS = 32;
    // result tdata width, one field padded to a byte
    localparam int OUT_DATA_BITS = 8;

    // turns evaluated per vertex: one running, two wrap-around at face end
    localparam int TURN_COUNT = 3;
    localparam int TURN_RUN = 0;
    localparam int TURN_WRAP_LAST = 1;
    localparam int TURN_WRAP_FIRST = 2;

    // vertex count codes, count saturates at COUNT_FULL
    localparam logic [2:0] COUNT_EMPTY = 3'd0;
    localparam logic [2:0] COUNT_ONE = 3'd1;
    localparam logic [2:0] COUNT_TRIPLE = 3'd2;
    localparam logic [2:0] COUNT_WRAP = 3'd3;
    localparam logic [2:0] COUNT_FULL = 3'd4;

    // control that travels with a vertex down the pipeline
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic                  skip;
        logic [TURN_COUNT-1:0] turn_en;
    } t_stage_ctl;

endpackage

// ===== src/pcc_front.sv =====
// pcc_front: vertex history of the current face and edge vector stage
// depends on pcc_pkg
`timescale 1ns / 1ps

module pcc_front #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_advance,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic                   i_last,
    output pcc_pkg::t_stage_ctl    o_ctl,
    output logic signed [DW-1:0]   o_abx [pcc_pkg::TURN_COUNT],
    output logic signed [DW-1:0]   o_aby [pcc_pkg::TURN_COUNT],
    output logic signed [DW-1:0]   o_bcx [pcc_pkg::TURN_COUNT],
    output logic signed [DW-1:0]   o_bcy [pcc_pkg::TURN_COUNT]
);
    import pcc_pkg::*;

    logic [2:0] r_count;
    logic [2:0] n_count;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y;
    logic signed [COORD_BITS-1:0] r_second_x, r_second_y;
    logic signed [COORD_BITS-1:0] r_older_x, r_older_y;
    logic signed [COORD_BITS-1:0] r_newer_x, r_newer_y;

    logic signed [COORD_BITS-1:0] a_x [TURN_COUNT];
    logic signed [COORD_BITS-1:0] a_y [TURN_COUNT];
    logic signed [COORD_BITS-1:0] b_x [TURN_COUNT];
    logic signed [COORD_BITS-1:0] b_y [TURN_COUNT];
    logic signed [COORD_BITS-1:0] c_x [TURN_COUNT];
    logic signed [COORD_BITS-1:0] c_y [TURN_COUNT];

    t_stage_ctl r_ctl;
    t_stage_ctl n_ctl;
    logic signed [DW-1:0] r_abx [TURN_COUNT];
    logic signed [DW-1:0] r_aby [TURN_COUNT];
    logic signed [DW-1:0] r_bcx [TURN_COUNT];
    logic signed [DW-1:0] r_bcy [TURN_COUNT];

    // corner triples: running turn and the two closing turns of the face
    always_comb begin
        a_x[TURN_RUN] = r_older_x;         a_y[TURN_RUN] = r_older_y;
        b_x[TURN_RUN] = r_newer_x;         b_y[TURN_RUN] = r_newer_y;
        c_x[TURN_RUN] = i_vertex_x;        c_y[TURN_RUN] = i_vertex_y;
        a_x[TURN_WRAP_LAST] = r_newer_x;   a_y[TURN_WRAP_LAST] = r_newer_y;
        b_x[TURN_WRAP_LAST] = i_vertex_x;  b_y[TURN_WRAP_LAST] = i_vertex_y;
        c_x[TURN_WRAP_LAST] = r_first_x;   c_y[TURN_WRAP_LAST] = r_first_y;
        a_x[TURN_WRAP_FIRST] = i_vertex_x; a_y[TURN_WRAP_FIRST] = i_vertex_y;
        b_x[TURN_WRAP_FIRST] = r_first_x;  b_y[TURN_WRAP_FIRST] = r_first_y;
        c_x[TURN_WRAP_FIRST] = r_second_x; c_y[TURN_WRAP_FIRST] = r_second_y;
    end

    // turn enables and face bookkeeping
    always_comb begin
        n_ctl = '0;
        n_ctl.valid = i_accept;
        n_ctl.last = i_last;
        n_ctl.skip = i_last && (r_count < COUNT_WRAP);
        n_ctl.turn_en[TURN_RUN] = (r_count >= COUNT_TRIPLE);
        n_ctl.turn_en[TURN_WRAP_LAST] = i_last && (r_count >= COUNT_WRAP);
        n_ctl.turn_en[TURN_WRAP_FIRST] = i_last && (r_count >= COUNT_WRAP);
        if (i_last) begin
            n_count = COUNT_EMPTY;
        end else if (r_count >= COUNT_WRAP) begin
            n_count = COUNT_FULL;
        end else begin
            n_count = r_count + 3'd1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_EMPTY;
            r_ctl <= '0;
        end else begin
            if (i_accept) begin
                r_count <= n_count;
            end
            if (i_advance) begin
                r_ctl <= n_ctl;
            end
        end
    end

    // vertex history and edge vectors
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (r_count == COUNT_EMPTY) begin
                r_first_x <= i_vertex_x;
                r_first_y <= i_vertex_y;
            end
            if (r_count == COUNT_ONE) begin
                r_second_x <= i_vertex_x;
                r_second_y <= i_vertex_y;
            end
            r_older_x <= r_newer_x;
            r_older_y <= r_newer_y;
            r_newer_x <= i_vertex_x;
            r_newer_y <= i_vertex_y;
            for (int k = 0; k < TURN_COUNT; k++) begin
                r_abx[k] <= DW'(b_x[k]) - DW'(a_x[k]);
                r_aby[k] <= DW'(b_y[k]) - DW'(a_y[k]);
                r_bcx[k] <= DW'(c_x[k]) - DW'(b_x[k]);
                r_bcy[k] <= DW'(c_y[k]) - DW'(b_y[k]);
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_abx = r_abx;
    assign o_aby = r_aby;
    assign o_bcx = r_bcx;
    assign o_bcy = r_bcy;

endmodule

// ===== src/pcc_mult.sv =====
// pcc_mult: product stage, two multiplies for each of the three turns
// depends on pcc_pkg
`timescale 1ns / 1ps

module pcc_mult #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 1,
    localparam int PW = 2 * DW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  pcc_pkg::t_stage_ctl  i_ctl,
    input  logic signed [DW-1:0] i_abx [pcc_pkg::TURN_COUNT],
    input  logic signed [DW-1:0] i_aby [pcc_pkg::TURN_COUNT],
    input  logic signed [DW-1:0] i_bcx [pcc_pkg::TURN_COUNT],
    input  logic signed [DW-1:0] i_bcy [pcc_pkg::TURN_COUNT],
    output pcc_pkg::t_stage_ctl  o_ctl,
    output logic signed [PW-1:0] o_prod_a [pcc_pkg::TURN_COUNT],
    output logic signed [PW-1:0] o_prod_b [pcc_pkg::TURN_COUNT]
);
    import pcc_pkg::*;

    t_stage_ctl r_ctl;
    logic signed [PW-1:0] r_prod_a [TURN_COUNT];
    logic signed [PW-1:0] r_prod_b [TURN_COUNT];

    // control follows the request down the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_advance) begin
            r_ctl <= i_ctl;
        end
    end

    // ab.x * bc.y and ab.y * bc.x per turn
    always_ff @(posedge i_clk) begin
        if (i_advance && i_ctl.valid) begin
            for (int k = 0; k < TURN_COUNT; k++) begin
                r_prod_a[k] <= PW'(i_abx[k]) * PW'(i_bcy[k]);
                r_prod_b[k] <= PW'(i_aby[k]) * PW'(i_bcx[k]);
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_prod_a = r_prod_a;
    assign o_prod_b = r_prod_b;

endmodule

// ===== src/pcc_judge.sv =====
// pcc_judge: threshold register, turn classification, face flags and result register
// depends on pcc_pkg
`timescale 1ns / 1ps

module pcc_judge #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 1,
    localparam int PW = 2 * DW,
    localparam int XW = PW + 1,
    localparam int CW = (XW > pcc_pkg::EPS_BITS + 1) ? XW : pcc_pkg::EPS_BITS + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_consume,
    input  logic                 i_out_ready,
    input  pcc_pkg::t_stage_ctl  i_ctl,
    input  logic signed [PW-1:0] i_prod_a [pcc_pkg::TURN_COUNT],
    input  logic signed [PW-1:0] i_prod_b [pcc_pkg::TURN_COUNT],
    input  logic                 i_cfg_we,
    input  logic [pcc_pkg::EPS_BITS-1:0] i_cfg_wdata,
    output logic                 o_valid,
    output logic                 o_concave,
    output logic                 o_skipped
);
    import pcc_pkg::*;

    logic [EPS_BITS-1:0] r_eps;
    logic signed [CW-1:0] eps_pos;
    logic signed [CW-1:0] eps_neg;
    logic signed [XW-1:0] cross_val [TURN_COUNT];
    logic signed [CW-1:0] cross_ext [TURN_COUNT];
    logic [TURN_COUNT-1:0] left_hit;
    logic [TURN_COUNT-1:0] right_hit;
    logic any_left;
    logic any_right;
    logic r_left;
    logic r_right;
    logic r_valid;
    logic r_concave;
    logic r_skipped;

    // compare each enabled cross product against the dead band
    always_comb begin
        eps_pos = $signed(CW'(r_eps));
        eps_neg = -eps_pos;
        for (int k = 0; k < TURN_COUNT; k++) begin
            cross_val[k] = XW'(i_prod_a[k]) - XW'(i_prod_b[k]);
            cross_ext[k] = CW'(cross_val[k]);
            left_hit[k] = i_ctl.turn_en[k] && (cross_ext[k] > eps_pos);
            right_hit[k] = i_ctl.turn_en[k] && (cross_ext[k] < eps_neg);
        end
        any_left = r_left || (|left_hit);
        any_right = r_right || (|right_hit);
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= '0;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // turn flags of the open face, cleared at face end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 1'b0;
            r_right <= 1'b0;
        end else if (i_consume) begin
            if (i_ctl.last) begin
                r_left <= 1'b0;
                r_right <= 1'b0;
            end else begin
                r_left <= any_left;
                r_right <= any_right;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_consume && i_ctl.last) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_consume && i_ctl.last) begin
            r_concave <= !i_ctl.skip && any_left && any_right;
            r_skipped <= i_ctl.skip;
        end
    end

    assign o_valid = r_valid;
    assign o_concave = r_concave;
    assign o_skipped = r_skipped;

endmodule

// ===== src/polygon_concavity_check_unit.sv =====
// Result path: a face's last vertex is registered in the edge stage, then the product stage,
// then the result register of the compare stage, before its result can be accepted.
// Throughput: one vertex per cycle; a face end held in the product stage behind a waiting
// result stalls the edge stage and the vertex input until the result is taken.
// Reset: synchronous, active low; clears the pipeline, face state and turn_epsilon.
// polygon_concavity_check_unit: top level, stream ports and stage flow control
`timescale 1ns / 1ps

module polygon_concavity_check_unit #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config: turn_epsilon
    input  logic                    i_cfg_we,
    input  logic [pcc_pkg::EPS_BITS-1:0] i_cfg_wdata,
    // vertex stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata from bit 0: vertex_x, vertex_y, zero padding
    input  logic [IN_DATA_BITS-1:0] s_axis_tdata,
    // tlast: last_of_face
    input  logic                    s_axis_tlast,
    // face result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata from bit 0: face_concave, zero padding
    output logic [pcc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // tuser from bit 0: face_skipped
    output logic [0:0]              m_axis_tuser
);
    import pcc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    t_stage_ctl edge_ctl;
    t_stage_ctl prod_ctl;
    logic signed [DW-1:0] abx [TURN_COUNT];
    logic signed [DW-1:0] aby [TURN_COUNT];
    logic signed [DW-1:0] bcx [TURN_COUNT];
    logic signed [DW-1:0] bcy [TURN_COUNT];
    logic signed [PW-1:0] prod_a [TURN_COUNT];
    logic signed [PW-1:0] prod_b [TURN_COUNT];
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic out_valid;
    logic out_concave;
    logic out_skipped;
    logic out_free;
    logic prod_advance;
    logic edge_advance;
    logic accept;

    // flow control: a stage moves when the one after it has room
    always_comb begin
        out_free = !out_valid || m_axis_tready;
        prod_advance = !prod_ctl.valid || !prod_ctl.last || out_free;
        edge_advance = !edge_ctl.valid || prod_advance;
        accept = s_axis_tvalid && edge_advance;
    end

    assign vertex_x = $signed(s_axis_tdata[COORD_BITS-1:0]);
    assign vertex_y = $signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);

    pcc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_advance  (edge_advance),
        .i_vertex_x (vertex_x),
        .i_vertex_y (vertex_y),
        .i_last     (s_axis_tlast),
        .o_ctl      (edge_ctl),
        .o_abx      (abx),
        .o_aby      (aby),
        .o_bcx      (bcx),
        .o_bcy      (bcy)
    );

    pcc_mult #(.COORD_BITS(COORD_BITS)) u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (prod_advance),
        .i_ctl     (edge_ctl),
        .i_abx     (abx),
        .i_aby     (aby),
        .i_bcx     (bcx),
        .i_bcy     (bcy),
        .o_ctl     (prod_ctl),
        .o_prod_a  (prod_a),
        .o_prod_b  (prod_b)
    );

    pcc_judge #(.COORD_BITS(COORD_BITS)) u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_consume   (prod_ctl.valid && prod_advance),
        .i_out_ready (m_axis_tready),
        .i_ctl       (prod_ctl),
        .i_prod_a    (prod_a),
        .i_prod_b    (prod_b),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (out_valid),
        .o_concave   (out_concave),
        .o_skipped   (out_skipped)
    );

    assign s_axis_tready = edge_advance;
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata = {{(OUT_DATA_BITS - 1){1'b0}}, out_concave};
    assign m_axis_tuser = out_skipped;

endmodule

// ===== src/pcc_checker.sv =====
// pcc_checker: port-level assertions for polygon_concavity_check_unit, with its bind
// depends on pcc_pkg and polygon_concavity_check_unit
`timescale 1ns / 1ps

module pcc_checker #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic [IN_DATA_BITS-1:0] s_axis_tdata,
    input logic                    s_axis_tlast,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [pcc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [0:0]              m_axis_tuser
);
    import pcc_pkg::*;

    // a skipped face is never reported as concave
    a_skip_not_concave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tuser[0]))
        else $error("skipped face flagged concave");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_BITS-1:1] == '0))
        else $error("result padding not zero");

    // a result after an empty output comes from a face end that passed the edge, product and result registers
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 3))
        else $error("result without a matching last vertex");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // a stalled vertex request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && !s_axis_tready) |=>
            (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast)))
        else $error("vertex request changed while stalled");

endmodule

bind polygon_concavity_check_unit pcc_checker #(.COORD_BITS(COORD_BITS)) u_pcc_checker (.*);

// ===== test/polygon_concavity_check_unit_test.sv =====
// polygon_concavity_check_unit_test: self-checking bench for the polygon concavity check unit
// drives vertex faces with random gaps and back-pressure, predicts each face verdict and compares
// depends on pcc_pkg and polygon_concavity_check_unit
`timescale 1ns / 1ps

module polygon_concavity_check_unit_test;

    localparam int COORD_W = pcc_pkg::COORD_BITS_DEF;
    localparam int VTX_BITS = ((2 * COORD_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_VERTICES = 170;
    localparam int PHASE_COUNT = 8;
    localparam int REPORT_MAX = 10;

    typedef struct {
        longint x;
        longint y;
    } point_t;

    typedef struct {
        bit concave;
        bit skipped;
    } face_verdict_t;

    // running convexity predictor and store of pending face verdicts
    class face_judge;
        longint unsigned turn_eps;
        point_t          first_pt;
        point_t          second_pt;
        point_t          older_pt;
        point_t          newer_pt;
        int unsigned     vtx_count;
        bit              saw_left;
        bit              saw_right;
        face_verdict_t   expected_verdicts[$];
        int              failures;

        function new();
            point_t zero_pt;
            zero_pt = '{0, 0};
            turn_eps = 0;
            first_pt = zero_pt;
            second_pt = zero_pt;
            older_pt = zero_pt;
            newer_pt = zero_pt;
            vtx_count = 0;
            saw_left = 0;
            saw_right = 0;
            failures = 0;
        endfunction

        function void classify(point_t a, point_t b, point_t c);
            longint cross_val;
            longint eps;
            cross_val = (b.x - a.x) * (c.y - b.y) - (b.y - a.y) * (c.x - b.x);
            eps = longint'(turn_eps);
            if (cross_val < -eps) begin
                saw_right = 1;
            end else if (cross_val > eps) begin
                saw_left = 1;
            end
        endfunction

        // accepted vertex request: advance the face and queue a verdict on the last one
        function void note_vertex(logic [VTX_BITS-1:0] data, logic last);
            point_t        v;
            face_verdict_t verdict;
            logic signed [COORD_W-1:0] cx;
            logic signed [COORD_W-1:0] cy;
            cx = data[COORD_W-1:0];
            cy = data[2*COORD_W-1:COORD_W];
            v.x = longint'(cx);
            v.y = longint'(cy);
            if (vtx_count == 0) begin
                first_pt = v;
            end else if (vtx_count == 1) begin
                second_pt = v;
            end else begin
                classify(older_pt, newer_pt, v);
            end
            older_pt = newer_pt;
            newer_pt = v;
            vtx_count = (vtx_count >= 3) ? 4 : vtx_count + 1;
            if (last) begin
                if (vtx_count < 4) begin
                    verdict.concave = 0;
                    verdict.skipped = 1;
                end else begin
                    // wrap-around turns close the face
                    classify(older_pt, newer_pt, first_pt);
                    classify(newer_pt, first_pt, second_pt);
                    verdict.concave = saw_left && saw_right;
                    verdict.skipped = 0;
                end
                expected_verdicts.push_back(verdict);
                vtx_count = 0;
                saw_left = 0;
                saw_right = 0;
            end
        endfunction

        // accepted result request: compare with the oldest verdict
        function void check_verdict(logic concave, logic skipped);
            face_verdict_t exp_v;
            if (expected_verdicts.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected face result: concave %0b skipped %0b", concave, skipped);
            end else begin
                exp_v = expected_verdicts.pop_front();
                if (concave !== exp_v.concave || skipped !== exp_v.skipped) begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("face mismatch: concave exp %0b got %0b, skipped exp %0b got %0b",
                                 exp_v.concave, concave, exp_v.skipped, skipped);
                end
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [pcc_pkg::EPS_BITS-1:0]         i_cfg_wdata;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    // tdata from bit 0: vertex_x, vertex_y
    logic [VTX_BITS-1:0]                  s_axis_tdata;
    // tlast: last_of_face
    logic                                 s_axis_tlast;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    // tdata from bit 0: face_concave, zero padding
    logic [pcc_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata;
    // tuser from bit 0: face_skipped
    logic [0:0]                           m_axis_tuser;

    face_judge judge;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        quiet_cycles;

    polygon_concavity_check_unit #(
        .COORD_BITS(COORD_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watch both request streams
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                judge.note_vertex(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                judge.check_verdict(m_axis_tdata[0], m_axis_tuser[0]);
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one vertex request, held until accepted
    task automatic send_vertex(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
                               input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {vy, vx};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold the sender until every queued verdict has come back
    task automatic wait_verdicts_drained();
        s_axis_tvalid <= 1'b0;
        while (judge.pending() != 0) @(posedge i_clk);
    endtask

    // threshold write with the block idle
    task automatic write_turn_eps(input logic [pcc_pkg::EPS_BITS-1:0] value);
        wait_verdicts_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        judge.turn_eps = value;
    endtask

    // one random face: noise, a local cluster, or an octagon walk with jitter
    task automatic send_random_face(output int nv);
        int dir_x[8];
        int dir_y[8];
        int pick;
        int kind;
        int cx;
        int cy;
        int scale;
        int jit;
        int idx;
        int rev;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        dir_x = '{4, 3, 0, -3, -4, -3, 0, 3};
        dir_y = '{0, 3, 4, 3, 0, -3, -4, -3};
        pick = $urandom_range(99);
        if (pick < 12) begin
            nv = $urandom_range(3, 1);
        end else if (pick < 92) begin
            nv = $urandom_range(8, 4);
        end else begin
            nv = $urandom_range(16, 9);
        end
        kind = $urandom_range(9);
        cx = $urandom_range(40000) - 20000;
        cy = $urandom_range(40000) - 20000;
        scale = ($urandom_range(3) == 0) ? $urandom_range(2000, 1) : $urandom_range(40, 1);
        jit = $urandom_range(3) == 0 ? $urandom_range(64) : 0;
        rev = $urandom_range(1);
        px = '0;
        py = '0;
        for (int i = 0; i < nv; i++) begin
            if (kind < 2) begin
                px = COORD_W'($urandom);
                py = COORD_W'($urandom);
            end else if (kind < 4) begin
                px = COORD_W'(cx + int'($urandom_range(128)) - 64);
                py = COORD_W'(cy + int'($urandom_range(128)) - 64);
            end else if (i > 0 && $urandom_range(9) == 0) begin
                // repeated vertex gives a straight turn
                px = px;
            end else begin
                idx = (nv <= 8) ? (i * 8) / nv : i % 8;
                if (rev)
                    idx = (8 - idx) % 8;
                px = COORD_W'(cx + dir_x[idx] * scale + int'($urandom_range(2 * jit)) - jit);
                py = COORD_W'(cy + dir_y[idx] * scale + int'($urandom_range(2 * jit)) - jit);
            end
            send_vertex(px, py, i == nv - 1);
        end
    endtask

    // main sequence
    initial begin
        int sent;
        int nv;
        bit paused;
        logic [pcc_pkg::EPS_BITS-1:0] eps_val;
        judge = new();
        quiet_cycles <= 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // convex square
        send_vertex(16'd0, 16'd0, 1'b0);
        send_vertex(16'd256, 16'd0, 1'b0);
        send_vertex(16'd256, 16'd256, 1'b0);
        send_vertex(16'd0, 16'd256, 1'b1);
        // dart with one reflex corner
        send_vertex(16'd0, 16'd0, 1'b0);
        send_vertex(16'd1024, 16'd0, 1'b0);
        send_vertex(16'd256, 16'd256, 1'b0);
        send_vertex(16'd0, 16'd1024, 1'b1);
        // short faces of one, two and three vertices
        send_vertex(16'h7FFF, 16'h8000, 1'b1);
        send_vertex(16'd5, 16'd7, 1'b0);
        send_vertex(16'hFFFF, 16'hFFFF, 1'b1);
        send_vertex(16'd0, 16'd0, 1'b0);
        send_vertex(16'd100, 16'd0, 1'b0);
        send_vertex(16'd0, 16'd100, 1'b1);
        // coordinate extremes
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h0000, 16'h0000, 1'b0);
        send_vertex(16'h8000, 16'h7FFF, 1'b1);
        // all vertices on one line, every turn straight
        send_vertex(16'd0, 16'd0, 1'b0);
        send_vertex(16'd10, 16'd10, 1'b0);
        send_vertex(16'd20, 16'd20, 1'b0);
        send_vertex(16'd30, 16'd30, 1'b1);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: eps_val = 32'd1;
                1: eps_val = 32'hFFFF_FFFF;
                2: eps_val = 32'd0;
                3: eps_val = $urandom;
                4: eps_val = 32'd4096;
                5: eps_val = $urandom_range(100000);
                6: eps_val = 32'h8000_0000;
                default: eps_val = 32'd0;
            endcase
            write_turn_eps(eps_val);
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 84;
                end
                default: begin
                    send_idle_pct = 35;
                    recv_stall_pct = 35;
                end
            endcase
            sent = 0;
            paused = 0;
            while (sent < PHASE_VERTICES) begin
                send_random_face(nv);
                sent += nv;
                if (!paused && sent >= PHASE_VERTICES / 2) begin
                    wait_verdicts_drained();
                    paused = 1;
                end
            end
        end

        // drain and let the pipeline settle
        wait_verdicts_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (judge.failures == 0 && judge.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pcc_pkg.sv
src/pcc_front.sv
src/pcc_mult.sv
src/pcc_judge.sv
src/polygon_concavity_check_unit.sv
src/pcc_checker.sv
test/polygon_concavity_check_unit_test.sv
